### rtl/script_text_tokenizer_assert.svh
// Assertion macros for the script text tokenizer.
// Included by the RTL files that carry concurrent checks; they expect clk and rst_n in scope.
`ifndef SCRIPT_TEXT_TOKENIZER_ASSERT_SVH
`define SCRIPT_TEXT_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// A property that must hold in the same cycle as its condition.
`define STT_ASSERT_NOW(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
// A property whose consequence is checked in the cycle after its condition.
`define STT_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define STT_ASSERT_NOW(lbl, cond, expr, msg)
`define STT_ASSERT_NEXT(lbl, cond, expr, msg)
`endif
`endif

### rtl/stt_pkg.sv
// Shared types and constants for the script text tokenizer.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package stt_pkg;

    localparam int MAX_TOKEN_LEN = 255;
    localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int RESULTS_MAX   = 3;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        TK_EOI  = 3'd0,
        TK_ERR  = 3'd1,
        TK_LPAR = 3'd2,
        TK_RPAR = 3'd3,
        TK_SYM  = 3'd4,
        TK_INT  = 3'd5,
        TK_FLT  = 3'd6,
        TK_STR  = 3'd7
    } token_kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_out;
        logic [2:0] token_kind;
        logic       overflow;
        logic       last;
    } out_item_t;

    // All results caused by one input item; slot[0] goes out first.
    typedef struct packed {
        out_item_t [RESULTS_MAX-1:0] slot;
        logic [1:0]                  count;
    } bundle_t;

endpackage

`default_nettype wire

### rtl/stt_lexer.sv
// Lexer state and the single-pass step logic that turns one item into its results.
// Depends on stt_pkg.
`default_nettype none

module stt_lexer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire stt_pkg::in_item_t item,
    output stt_pkg::bundle_t       bundle
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_LINE  = 3'd1,
        ST_BLOCK = 3'd2,
        ST_BAR   = 3'd3,
        ST_HASH  = 3'd4,
        ST_SYM   = 3'd5,
        ST_NUM   = 3'd6,
        ST_STR   = 3'd7
    } lex_state_t;

    lex_state_t                 state_reg, state_next;
    logic                       float_reg, float_next;
    logic [stt_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                       ovf_reg, ovf_next;

    stt_pkg::out_item_t [stt_pkg::RESULTS_MAX-1:0] res;
    logic [1:0]  n;
    logic        reproc;
    logic [7:0]  c;
    logic        c_space;
    logic        c_digit;

    function automatic stt_pkg::out_item_t mk(input logic kind, input logic [7:0] ch,
                                              input logic [2:0] tk, input logic ovf);
        stt_pkg::out_item_t r;
        r.kind       = kind;
        r.char_out   = ch;
        r.token_kind = tk;
        r.overflow   = ovf;
        r.last       = 1'b0;
        return r;
    endfunction

    assign c       = item.in_byte;
    assign c_space = (c == stt_pkg::CH_SPACE) || (c == stt_pkg::CH_CR) ||
                     (c == stt_pkg::CH_LF) || (c == stt_pkg::CH_TAB);
    assign c_digit = (c >= stt_pkg::CH_ZERO) && (c <= stt_pkg::CH_NINE);

    always_comb
    begin
        state_next = state_reg;
        float_next = float_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        res        = '0;
        n          = 2'd0;
        reproc     = 1'b0;

        if (item.end_of_input)
        begin
            case (state_reg)
                ST_SYM:
                begin
                    res[n] = mk(1'b1, 8'd0, stt_pkg::TK_SYM, ovf_reg);
                    n = n + 2'd1;
                end
                ST_NUM:
                begin
                    res[n] = mk(1'b1, 8'd0, float_reg ? stt_pkg::TK_FLT : stt_pkg::TK_INT,
                                ovf_reg);
                    n = n + 2'd1;
                end
                ST_STR:
                begin
                    res[n] = mk(1'b1, 8'd0, stt_pkg::TK_ERR, ovf_reg);
                    n = n + 2'd1;
                end
                ST_HASH:
                begin
                    res[n] = mk(1'b1, 8'd0, stt_pkg::TK_ERR, 1'b0);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            res[n] = mk(1'b1, 8'd0, stt_pkg::TK_EOI, 1'b0);
            n = n + 2'd1;
            state_next = ST_IDLE;
            float_next = 1'b0;
            len_next   = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_LINE:
                begin
                    if (c == stt_pkg::CH_CR || c == stt_pkg::CH_LF)
                        state_next = ST_IDLE;
                end
                ST_BLOCK:
                begin
                    if (c == stt_pkg::CH_BAR)
                        state_next = ST_BAR;
                end
                ST_BAR:
                begin
                    state_next = (c == stt_pkg::CH_HASH) ? ST_IDLE : ST_BLOCK;
                end
                ST_HASH:
                begin
                    if (c == stt_pkg::CH_BAR)
                        state_next = ST_BLOCK;
                    else
                    begin
                        res[n] = mk(1'b1, 8'd0, stt_pkg::TK_ERR, 1'b0);
                        n = n + 2'd1;
                        state_next = ST_IDLE;
                    end
                end
                ST_SYM:
                begin
                    if (!c_space && c != stt_pkg::CH_LPAREN && c != stt_pkg::CH_RPAREN &&
                        c != stt_pkg::CH_QUOTE)
                    begin
                        if (len_next < stt_pkg::LEN_W'(stt_pkg::MAX_TOKEN_LEN))
                        begin
                            res[n] = mk(1'b0, c, stt_pkg::TK_EOI, 1'b0);
                            n = n + 2'd1;
                            len_next = len_next + stt_pkg::LEN_W'(1);
                        end
                        else
                            ovf_next = 1'b1;
                    end
                    else
                    begin
                        res[n] = mk(1'b1, 8'd0, stt_pkg::TK_SYM, ovf_next);
                        n = n + 2'd1;
                        state_next = ST_IDLE;
                        reproc = 1'b1;
                    end
                end
                ST_NUM:
                begin
                    if (c_digit || c == stt_pkg::CH_DOT)
                    begin
                        if (c == stt_pkg::CH_DOT)
                            float_next = 1'b1;
                        if (len_next < stt_pkg::LEN_W'(stt_pkg::MAX_TOKEN_LEN))
                        begin
                            res[n] = mk(1'b0, c, stt_pkg::TK_EOI, 1'b0);
                            n = n + 2'd1;
                            len_next = len_next + stt_pkg::LEN_W'(1);
                        end
                        else
                            ovf_next = 1'b1;
                    end
                    else
                    begin
                        res[n] = mk(1'b1, 8'd0,
                                    float_next ? stt_pkg::TK_FLT : stt_pkg::TK_INT, ovf_next);
                        n = n + 2'd1;
                        state_next = ST_IDLE;
                        reproc = 1'b1;
                    end
                end
                ST_STR:
                begin
                    if (c != stt_pkg::CH_QUOTE)
                    begin
                        if (len_next < stt_pkg::LEN_W'(stt_pkg::MAX_TOKEN_LEN))
                        begin
                            res[n] = mk(1'b0, c, stt_pkg::TK_EOI, 1'b0);
                            n = n + 2'd1;
                            len_next = len_next + stt_pkg::LEN_W'(1);
                        end
                        else
                            ovf_next = 1'b1;
                    end
                    else
                    begin
                        res[n] = mk(1'b1, 8'd0, stt_pkg::TK_STR, ovf_next);
                        n = n + 2'd1;
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                    reproc = 1'b1;
                end
            endcase

            // A byte seen between tokens, or one that closes a symbol or number, is then handled as between tokens.
            if (reproc)
            begin
                if (c == stt_pkg::CH_SEMI)
                    state_next = ST_LINE;
                else if (c == stt_pkg::CH_HASH)
                    state_next = ST_HASH;
                else if (c == stt_pkg::CH_LPAREN || c == stt_pkg::CH_RPAREN)
                begin
                    state_next = ST_IDLE;
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    float_next = 1'b0;
                    res[n] = mk(1'b0, c, stt_pkg::TK_EOI, 1'b0);
                    n = n + 2'd1;
                    res[n] = mk(1'b1, 8'd0, (c == stt_pkg::CH_LPAREN) ? stt_pkg::TK_LPAR :
                                stt_pkg::TK_RPAR, 1'b0);
                    n = n + 2'd1;
                end
                else if (c == stt_pkg::CH_QUOTE)
                begin
                    state_next = ST_STR;
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    float_next = 1'b0;
                end
                else if (!c_space)
                begin
                    state_next = (c_digit || c == stt_pkg::CH_MINUS) ? ST_NUM : ST_SYM;
                    ovf_next   = 1'b0;
                    float_next = 1'b0;
                    // Any length limit of one or more lets the first character through.
                    res[n] = mk(1'b0, c, stt_pkg::TK_EOI, 1'b0);
                    n = n + 2'd1;
                    len_next = stt_pkg::LEN_W'(1);
                end
            end
        end

        if (n != 2'd0)
            res[n - 2'd1].last = 1'b1;
    end

    assign bundle.slot  = res;
    assign bundle.count = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            float_reg <= 1'b0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            float_reg <= float_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

### rtl/stt_result_buf.sv
// Result register that holds one item's results and sends them out one per cycle unless stalled.
// Depends on stt_pkg and the assertion macro header.
`default_nettype none

`include "script_text_tokenizer_assert.svh"

module stt_result_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire stt_pkg::bundle_t   bundle,
    output logic                    ready,
    output logic                    valid,
    input  wire logic               stall,
    output stt_pkg::out_item_t      item
);

    stt_pkg::out_item_t [stt_pkg::RESULTS_MAX-1:0] slot_reg;
    logic [1:0] cnt_reg;
    logic       out_fire;

    assign valid    = (cnt_reg != 2'd0);
    assign item     = slot_reg[0];
    assign out_fire = valid && !stall;
    // The last waiting result may leave in the same cycle that the next bundle arrives.
    assign ready    = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (load)
            cnt_reg <= bundle.count;
        else if (out_fire)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= bundle.slot;
        else if (out_fire)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    `STT_ASSERT_NOW(a_last_on_final, cnt_reg == 2'd1, slot_reg[0].last, "final result lacks last")
    `STT_ASSERT_NOW(a_no_early_last, cnt_reg > 2'd1, !slot_reg[0].last, "last before final result")
    `STT_ASSERT_NEXT(a_drain_empty, out_fire && cnt_reg == 2'd1 && !load, !valid,
                     "result buffer did not empty")

endmodule

`default_nettype wire

### rtl/script_text_tokenizer.sv
// Top level of the script text tokenizer; depends on stt_pkg, stt_lexer and stt_result_buf.
// An accepted item is held in the input register, passes through the lexer into the result
// register once that register is ready, and its first result is then offered from there.
// Throughput: one item per cycle while the input is not stalled; an item gives at most three results,
// and the input stalls while two or more results wait or the receiver stalls the last one.
// Reset is asynchronous, active low, and returns the lexer to idle with the buffers empty.
`default_nettype none

module script_text_tokenizer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               text_valid,
    output logic                    text_stall,
    input  wire stt_pkg::in_item_t  text_item,
    output logic                    token_valid,
    input  wire logic               token_stall,
    output stt_pkg::out_item_t      token_item
);

    logic               in_valid_reg;
    stt_pkg::in_item_t  in_item_reg;
    logic               buf_ready;
    logic               load;
    logic               accept;
    stt_pkg::bundle_t   bundle;

    assign load       = in_valid_reg && buf_ready;
    assign text_stall = in_valid_reg && !load;
    assign accept     = text_valid && !text_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (load)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= text_item;
    end

    stt_lexer u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (load),
        .item   (in_item_reg),
        .bundle (bundle)
    );

    stt_result_buf u_result_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .bundle (bundle),
        .ready  (buf_ready),
        .valid  (token_valid),
        .stall  (token_stall),
        .item   (token_item)
    );

endmodule

`default_nettype wire
